/* rtl/gj3_pkg.sv */
`timescale 1ns / 1ps
package gj3_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OP_SETUP,
    ST_DIV_RUN,
    ST_MUL_RUN,
    ST_MUL_WB,
    ST_OUT
  } gj3_state_t;

  typedef enum logic [0:0] {
    OP_NORM,
    OP_ELIM
  } gj3_op_t;

  // one step of the solve: operation, target row, source row, pivot column
  typedef struct packed {
    gj3_op_t    op;
    logic [1:0] row;
    logic [1:0] src;
    logic [1:0] piv;
  } gj3_step_t;

  localparam int NUM_STEPS = 9;

  function automatic gj3_step_t step_rom(input logic [3:0] idx);
    gj3_step_t s;
    case (idx)
      4'd0:    s = '{OP_NORM, 2'd0, 2'd0, 2'd0};
      4'd1:    s = '{OP_ELIM, 2'd1, 2'd0, 2'd0};
      4'd2:    s = '{OP_ELIM, 2'd2, 2'd0, 2'd0};
      4'd3:    s = '{OP_NORM, 2'd1, 2'd1, 2'd1};
      4'd4:    s = '{OP_ELIM, 2'd2, 2'd1, 2'd1};
      4'd5:    s = '{OP_NORM, 2'd2, 2'd2, 2'd2};
      4'd6:    s = '{OP_ELIM, 2'd0, 2'd1, 2'd1};
      4'd7:    s = '{OP_ELIM, 2'd0, 2'd2, 2'd2};
      4'd8:    s = '{OP_ELIM, 2'd1, 2'd2, 2'd2};
      default: s = '{OP_NORM, 2'd0, 2'd0, 2'd0};
    endcase
    return s;
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic [3:0] load_idx;
    logic       clear_flag;
    logic       setup;
    gj3_step_t  step;
    logic [1:0] col;
    logic       div_start;
    logic       div_step;
    logic       mul_capture;
    logic       mul_wb;
    logic       div_wb;
  } gj3_cmd_t;

  // status back to controller
  typedef struct packed {
    logic piv_zero;
    logic div_done;
  } gj3_stat_t;

endpackage

/* rtl/gauss_jordan_3x3_solver.sv */
`timescale 1ns / 1ps
// gauss-jordan solver for a 3x3 system in signed fixed point
// input channel: coeff_value words with in_valid/in_stall, twelve words per
//   system, row-major over the 3x4 augmented matrix
// output channel: three words x1, x2, x3 with out_valid/out_stall; each carries
//   unknown_index, last_result on the third, and singular if a pivot was zero
// solve: after the twelfth word the solve runs nine row steps, each through a
//   setup state and an advance state; a normalize step runs one restoring
//   division per column (start, one quotient bit per cycle, write back) unless
//   its pivot is zero, an eliminate step a multiply, then a round-subtract per
//   column
// sequencing: one system at a time; the next system is taken only after the
//   third result word is accepted; input is stalled during solve and output
// under out_stall the current result word is held unchanged
// reset clears the load count, the singular flag and returns to loading
module gauss_jordan_3x3_solver import gj3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [31:0] coeff_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] solution_value,
  output logic [1:0]        unknown_index,
  output logic              last_result,
  output logic              singular
);
  gj3_cmd_t  cmd;
  gj3_stat_t stat;
  logic [1:0] out_row;

  gj3_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .stat(stat), .cmd(cmd)
  );

  gj3_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .coeff_value(coeff_value),
    .out_row(out_row), .stat(stat), .x_value(solution_value), .flag(singular)
  );

  assign unknown_index = out_row;
  assign last_result   = (out_row == 2'd2);

  // never accept input while a result word is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while output pending");

  // stalled result holds its index
  a_hold_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(unknown_index))
    else $error("result index moved under stall");

  // last word returns to loading
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid)
    else $error("output continued after last word");
endmodule

/* rtl/gj3_datapath.sv */
`timescale 1ns / 1ps
module gj3_datapath import gj3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gj3_cmd_t          cmd,
  input  logic signed [31:0] coeff_value,
  input  logic [1:0]        out_row,
  output gj3_stat_t         stat,
  output logic signed [31:0] x_value,
  output logic              flag
);
  localparam int NUM_W  = 32 + FRAC_BITS;
  localparam int QW     = NUM_W + 1;
  localparam int CNT_W  = $clog2(QW + 1);

  logic signed [31:0] mat [12];
  logic signed [31:0] piv_val;
  logic signed [31:0] fac_val;

  logic [3:0] a_idx;
  logic [3:0] b_idx;
  logic signed [31:0] a_val;
  logic signed [31:0] b_val;

  assign a_idx = 4'({cmd.step.row, cmd.col});
  assign b_idx = 4'({cmd.step.src, cmd.col});
  assign a_val = mat[a_idx];
  assign b_val = mat[b_idx];

  // restoring divider, one quotient bit per cycle
  logic [QW-1:0]  dnum;
  logic [32:0]    dden;
  logic [33:0]    drem;
  logic [CNT_W-1:0] dcnt;
  logic           dneg;
  logic [33:0]    drem_sh;
  logic [34:0]    dtrial;
  logic [QW:0]    qround;
  logic signed [QW+1:0] qsigned;
  logic signed [31:0] div_res;

  assign drem_sh = {drem[32:0], dnum[QW-1]};
  assign dtrial  = {1'b0, drem_sh} - {2'b0, dden};
  // quotient holds (num + den/2)/den: num pre-offset at start
  assign qround  = {1'b0, dnum};
  assign qsigned = dneg ? -$signed({1'b0, qround}) : $signed({1'b0, qround});
  always_comb begin
    if (qsigned > $signed((QW+2)'(32'sh7fffffff))) begin
      div_res = 32'sh7fffffff;
    end else if (qsigned < -$signed((QW+2)'(64'sh80000000))) begin
      div_res = 32'sh80000000;
    end else begin
      div_res = qsigned[31:0];
    end
  end

  logic [31:0] ma;
  logic [31:0] mb;
  assign ma = a_val[31] ? 32'(-a_val) : 32'(a_val);
  assign mb = piv_val[31] ? 32'(-piv_val) : 32'(piv_val);

  // multiply-subtract, product registered before rounding
  logic signed [63:0] prod;
  logic signed [31:0] acc_a;
  logic [63:0] pmag;
  logic [63:0] pq;
  logic signed [65:0] diff;
  logic signed [31:0] ms_res;

  assign pmag = prod[63] ? 64'(-prod) : 64'(prod);
  assign pq   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign diff = prod[63] ? (66'(acc_a) + $signed({2'b0, pq}))
                         : (66'(acc_a) - $signed({2'b0, pq}));
  always_comb begin
    if (diff > 66'sh7fffffff) begin
      ms_res = 32'sh7fffffff;
    end else if (diff < -66'sh80000000) begin
      ms_res = 32'sh80000000;
    end else begin
      ms_res = diff[31:0];
    end
  end

  // rounding offset mb>>1 is added by seeding the dividend: handle by
  // dividing (ma<<F)+(mb>>1); this sum fits NUM_W+1 bits
  logic [QW-1:0] num_init;
  assign num_init = ({1'b0, ma, FRAC_BITS'(0)}) + QW'(mb >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cmd.clear_flag) flag <= 1'b0;
      if (cmd.setup && cmd.step.op == OP_NORM && mat[4'({cmd.step.row, cmd.step.piv})] == 0)
        flag <= 1'b1;
      if (cmd.div_start) begin
        dcnt <= CNT_W'(QW);
      end else if (cmd.div_step && dcnt != 0) begin
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mat[cmd.load_idx] <= coeff_value;
    if (cmd.setup) begin
      piv_val <= mat[4'({cmd.step.row, cmd.step.piv})];
      fac_val <= mat[4'({cmd.step.row, cmd.step.piv})];
    end
    if (cmd.div_start) begin
      dnum <= num_init;
      dden <= {1'b0, mb};
      drem <= '0;
      dneg <= a_val[31] ^ piv_val[31];
    end else if (cmd.div_step && dcnt != 0) begin
      if (!dtrial[34]) begin
        drem <= dtrial[33:0];
        dnum <= {dnum[QW-2:0], 1'b1};
      end else begin
        drem <= drem_sh;
        dnum <= {dnum[QW-2:0], 1'b0};
      end
    end
    if (cmd.mul_capture) begin
      prod  <= 64'(b_val) * 64'(fac_val);
      acc_a <= a_val;
    end
    if (cmd.div_wb) mat[a_idx] <= div_res;
    if (cmd.mul_wb) mat[a_idx] <= ms_res;
  end

  assign stat.piv_zero = (mat[4'({cmd.step.row, cmd.step.piv})] == 0);
  assign stat.div_done = (dcnt == 0);
  assign x_value = mat[4'({out_row, 2'd3})];
endmodule

/* rtl/gj3_ctrl.sv */
`timescale 1ns / 1ps
module gj3_ctrl import gj3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [1:0] out_row,
  input  gj3_stat_t stat,
  output gj3_cmd_t  cmd
);
  gj3_state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [3:0] step_idx, step_idx_next;
  logic [1:0] col, col_next;
  logic [1:0] orow, orow_next;
  logic       dstarted, dstarted_next;
  gj3_step_t  cur;

  assign cur = step_rom(step_idx);
  assign out_row = orow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      step_idx <= '0;
      col      <= '0;
      orow     <= '0;
      dstarted <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      step_idx <= step_idx_next;
      col      <= col_next;
      orow     <= orow_next;
      dstarted <= dstarted_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    step_idx_next = step_idx;
    col_next      = col;
    orow_next     = orow;
    dstarted_next = dstarted;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.step      = cur;
    cmd.col       = col;
    cmd.load_idx  = cnt;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (cnt >= 4'd11) begin
            cnt_next      = '0;
            step_idx_next = '0;
            cmd.clear_flag = 1'b1;
            state_next    = ST_OP_SETUP;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      ST_OP_SETUP: begin
        cmd.setup     = 1'b1;
        col_next      = cur.piv;
        dstarted_next = 1'b0;
        if (cur.op == OP_NORM) begin
          if (stat.piv_zero) begin
            state_next = ST_MUL_WB;
            col_next   = 2'd3;
          end else begin
            state_next = ST_DIV_RUN;
          end
        end else begin
          state_next = ST_MUL_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (!dstarted) begin
          cmd.div_start = 1'b1;
          dstarted_next = 1'b1;
        end else if (!stat.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_wb    = 1'b1;
          dstarted_next = 1'b0;
          if (col == 2'd3) state_next = ST_MUL_WB;
          else col_next = col + 2'd1;
        end
      end
      ST_MUL_RUN: begin
        if (!dstarted) begin
          cmd.mul_capture = 1'b1;
          dstarted_next   = 1'b1;
        end else begin
          cmd.mul_wb    = 1'b1;
          dstarted_next = 1'b0;
          if (col == 2'd3) state_next = ST_MUL_WB;
          else col_next = col + 2'd1;
        end
      end
      ST_MUL_WB: begin
        // step finished, advance sequence
        if (step_idx == 4'(NUM_STEPS - 1)) begin
          orow_next  = '0;
          state_next = ST_OUT;
        end else begin
          step_idx_next = step_idx + 4'd1;
          state_next    = ST_OP_SETUP;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (orow == 2'd2) state_next = ST_LOAD;
          else orow_next = orow + 2'd1;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule
